// File: src/rwcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rwcl_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned STAT_W = 3;
	localparam int unsigned HDR_LEN = 8;

	localparam logic [WORD_W-1:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [WORD_W-1:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [WORD_W-1:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [WORD_W-1:0] TAG_FACT = 32'h6661_6374;
	localparam logic [WORD_W-1:0] TAG_CUE  = 32'h6375_6520;
	localparam logic [WORD_W-1:0] TAG_PLST = 32'h706C_7374;
	localparam logic [WORD_W-1:0] TAG_LIST = 32'h4C49_5354;
	localparam logic [WORD_W-1:0] TAG_DATA = 32'h6461_7461;

	localparam logic [KIND_W-1:0] KIND_FMT   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FACT  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CUE   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PLST  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_LIST  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_DATA  = 3'd5;
	localparam logic [KIND_W-1:0] KIND_OTHER = 3'd6;

	localparam logic [STAT_W-1:0] ST_RUNNING  = 3'd0;
	localparam logic [STAT_W-1:0] ST_DONE_OK  = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOT_RIFF = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_WAVE = 3'd3;
	localparam logic [STAT_W-1:0] ST_NO_FMT   = 3'd4;
	localparam logic [STAT_W-1:0] ST_EARLY_END = 3'd5;

	typedef enum logic [2:0] {
		PH_PRELUDE = 3'b001,
		PH_WALK    = 3'b010,
		PH_DONE    = 3'b100
	} phase_t;

	typedef struct packed {
		logic                record_valid;
		logic [KIND_W-1:0]   chunk_kind;
		logic [WORD_W-1:0]   data_offset;
		logic [WORD_W-1:0]   chunk_length;
		logic                truncated;
		logic [STAT_W-1:0]   status;
	} record_t;

	function automatic logic [KIND_W-1:0] kind_of(input logic [WORD_W-1:0] tag);
		logic [KIND_W-1:0] k;
		case (tag)
			TAG_FMT:  k = KIND_FMT;
			TAG_FACT: k = KIND_FACT;
			TAG_CUE:  k = KIND_CUE;
			TAG_PLST: k = KIND_PLST;
			TAG_LIST: k = KIND_LIST;
			TAG_DATA: k = KIND_DATA;
			default:  k = KIND_OTHER;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// File: src/rwcl_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rwcl_byte_if;
	import rwcl_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              start_of_buffer;

	modport source (output valid, data_byte, start_of_buffer, input ready);
	modport sink (input valid, data_byte, start_of_buffer, output ready);
endinterface

`default_nettype wire

// File: src/rwcl_rec_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rwcl_rec_if;
	import rwcl_pkg::*;

	logic              valid;
	logic              ready;
	logic              record_valid;
	logic [KIND_W-1:0] chunk_kind;
	logic [WORD_W-1:0] data_offset;
	logic [WORD_W-1:0] chunk_length;
	logic              truncated;
	logic [STAT_W-1:0] status;

	modport source (
		output valid, record_valid, chunk_kind, data_offset, chunk_length, truncated, status,
		input ready
	);
	modport sink (
		input valid, record_valid, chunk_kind, data_offset, chunk_length, truncated, status,
		output ready
	);
endinterface

`default_nettype wire

// File: src/rwcl_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rwcl_cfg_if;
	import rwcl_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: src/riff_wave_chunk_locator.sv
// RIFF/WAVE chunk header locator.
// byte_stream carries the file one byte per word, first byte flagged by
// start_of_buffer; each flagged byte restarts the parse at offset zero.
// records carries one word per completed chunk header (kind, data offset,
// length, clamped except for fmt) and one word per failed tag check, each
// with a status code. Bytes that complete nothing produce no word.
// cfg writes buffer_length, the total file size; write it between files.
// A byte's record passes through the input register, then the result
// register. The block takes one byte per cycle unless a held record stalls
// it, with the single decode stage between those two registers.
// A stalled receiver holds the record; the input register still takes one
// more byte, and bytes that yield no record keep flowing past the stall.
// Reset clears the parse state, the byte offset and buffer_length; the first
// byte after reset counts as offset zero even without the start flag.
// After success or an error, bytes are dropped until the next start flag.
`timescale 1ns / 1ps
`default_nettype none

module riff_wave_chunk_locator (
	input  wire            clk,
	input  wire            arst_n,
	rwcl_cfg_if.sink       cfg,
	rwcl_byte_if.sink      byte_stream,
	rwcl_rec_if.source     records
);
	import rwcl_pkg::*;

	logic [WORD_W-1:0] buf_len_q;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              sob_s1;

	logic [WORD_W-1:0] off_q;
	phase_t            phase_q;
	logic [WORD_W-1:0] wa_q;
	logic [WORD_W-1:0] tag_q;
	logic [WORD_W-1:0] nho_q;

	logic [WORD_W-1:0] off_e, wa_e, tag_e, nho_e;
	phase_t            phase_e;
	logic [WORD_W-1:0] off_n, wa_n, tag_n, nho_n;
	phase_t            phase_n;
	logic [WORD_W-1:0] tag_sh, wa_base, k;
	logic [4:0]        lane_sh;
	logic [WORD_W:0]   sum20, sum28, doff;
	logic [WORD_W+1:0] dend, walk_end;
	logic [WORD_W:0]   len33;
	logic              clamp, trunc;
	logic [KIND_W-1:0] kind;
	logic [WORD_W-1:0] size;
	logic              has_res;
	record_t           res;

	logic              out_valid_q;
	record_t           out_q;
	logic              advance, in_fire;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_len_q <= '0;
		end else if (cfg.valid) begin
			buf_len_q <= cfg.data;
		end
	end

	// a held record blocks the stage only if this byte makes another one
	assign advance = valid_s1 && (!has_res || !out_valid_q || records.ready);
	assign byte_stream.ready = !valid_s1 || advance;
	assign in_fire = byte_stream.valid && byte_stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= byte_stream.data_byte;
			sob_s1  <= byte_stream.start_of_buffer;
		end
	end

	always_comb begin
		off_e   = sob_s1 ? '0 : off_q;
		phase_e = sob_s1 ? PH_PRELUDE : phase_q;
		wa_e    = sob_s1 ? '0 : wa_q;
		tag_e   = sob_s1 ? '0 : tag_q;
		nho_e   = sob_s1 ? '0 : nho_q;

		off_n   = off_e + 32'd1;
		phase_n = phase_e;
		wa_n    = wa_e;
		tag_n   = tag_e;
		nho_n   = nho_e;

		tag_sh  = {tag_e[WORD_W-BYTE_W-1:0], byte_s1};
		k       = off_e - nho_e;
		lane_sh = '0;
		wa_base = wa_e;
		len33   = {1'b0, buf_len_q};
		sum20   = '0;
		sum28   = '0;
		clamp   = 1'b0;
		doff    = '0;
		dend    = '0;
		walk_end = '0;
		trunc   = 1'b0;
		size    = '0;
		kind    = kind_of(tag_e);
		has_res = 1'b0;
		res     = '0;

		case (phase_e)
			PH_PRELUDE: begin
				if (off_e < 32'd4 || (off_e >= 32'd8 && off_e < 32'd16)) begin
					tag_n = tag_sh;
				end
				if (off_e >= 32'd16 && off_e < 32'd20) begin
					lane_sh = {off_e[1:0], 3'b000};
					wa_base = (off_e == 32'd16) ? '0 : wa_e;
					wa_n = wa_base;
					wa_n[lane_sh +: BYTE_W] = wa_base[lane_sh +: BYTE_W] | byte_s1;
				end
				if (off_e == 32'd3 && tag_n != TAG_RIFF) begin
					has_res = 1'b1;
					res.status = ST_NOT_RIFF;
					phase_n = PH_DONE;
				end else if (off_e == 32'd11 && tag_n != TAG_WAVE) begin
					has_res = 1'b1;
					res.status = ST_NOT_WAVE;
					phase_n = PH_DONE;
				end else if (off_e == 32'd15 && tag_n != TAG_FMT) begin
					has_res = 1'b1;
					res.status = ST_NO_FMT;
					phase_n = PH_DONE;
				end else if (off_e == 32'd19) begin
					sum20 = {1'b0, wa_n} + 33'd20;
					sum28 = {1'b0, wa_n} + 33'd28;
					clamp = sum20 > len33;
					nho_n = clamp ? buf_len_q : sum20[WORD_W-1:0];
					has_res = 1'b1;
					res.record_valid = 1'b1;
					res.chunk_kind   = KIND_FMT;
					res.data_offset  = 32'd20;
					res.chunk_length = wa_n;
					// a clamped end always leaves no room for another header
					if (sum28 >= len33) begin
						res.status = ST_EARLY_END;
						phase_n = PH_DONE;
					end else begin
						res.status = ST_RUNNING;
						phase_n = PH_WALK;
					end
				end
			end
			PH_WALK: begin
				if (off_e >= nho_e) begin
					if (k < 32'd4) begin
						tag_n = tag_sh;
					end else if (k < 32'd8) begin
						lane_sh = {k[1:0], 3'b000};
						wa_base = (k == 32'd4) ? '0 : wa_e;
						wa_n = wa_base;
						wa_n[lane_sh +: BYTE_W] = wa_base[lane_sh +: BYTE_W] | byte_s1;
						if (k == 32'd7) begin
							doff = {1'b0, nho_e} + 33'd8;
							dend = {1'b0, doff} + {2'b00, wa_n};
							walk_end = {2'b00, nho_e} + {2'b00, wa_n} + 34'd16;
							trunc = dend >= {1'b0, len33};
							if (trunc) begin
								size = (len33 > doff) ? buf_len_q - doff[WORD_W-1:0] : '0;
							end else begin
								size = wa_n;
							end
							has_res = 1'b1;
							res.record_valid = 1'b1;
							res.chunk_kind   = kind;
							res.data_offset  = doff[WORD_W-1:0];
							res.chunk_length = size;
							res.truncated    = trunc;
							if (kind == KIND_DATA) begin
								res.status = ST_DONE_OK;
								phase_n = PH_DONE;
							end else if (trunc || walk_end >= {1'b0, len33}) begin
								res.status = ST_EARLY_END;
								phase_n = PH_DONE;
							end else begin
								res.status = ST_RUNNING;
								nho_n = dend[WORD_W-1:0];
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			phase_q <= PH_PRELUDE;
			wa_q    <= '0;
			tag_q   <= '0;
			nho_q   <= '0;
		end else if (advance) begin
			off_q   <= off_n;
			phase_q <= phase_n;
			wa_q    <= wa_n;
			tag_q   <= tag_n;
			nho_q   <= nho_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			out_valid_q <= 1'b1;
		end else if (records.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			out_q <= res;
		end
	end

	assign records.valid        = out_valid_q;
	assign records.record_valid = out_q.record_valid;
	assign records.chunk_kind   = out_q.chunk_kind;
	assign records.data_offset  = out_q.data_offset;
	assign records.chunk_length = out_q.chunk_length;
	assign records.truncated    = out_q.truncated;
	assign records.status       = out_q.status;

endmodule

`default_nettype wire
